### rtl/ssm_pkg.sv
// Shared types, constants and arithmetic helpers for the selective-scan head.
// Used by ssm_front, ssm_queue, ssm_back and ssm_selective_scan_head.
`timescale 1ns / 1ps

package ssm_pkg;

	localparam int STATE_DIM   = 16;
	localparam int HEAD_DIM    = 64;
	localparam int ENTRIES     = STATE_DIM * HEAD_DIM;
	localparam int ADDR_W      = $clog2(ENTRIES);
	localparam int N_W         = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
	localparam int DATA_W      = 32;
	localparam int INDEX_W     = 10;
	localparam int OP_W        = 3;
	localparam int ACC_W       = DATA_W + $clog2(STATE_DIM + 2);
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	localparam logic KIND_Y     = 1'b0;
	localparam logic KIND_STATE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_LOG_DECAY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_ENABLE = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 3'd0,
		OP_DT   = 3'd1,
		OP_BC   = 3'd2,
		OP_X    = 3'd3,
		OP_READ = 3'd4
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [INDEX_W-1:0]        index;
		logic signed [DATA_W-1:0]  value_a;
		logic signed [DATA_W-1:0]  value_b;
	} in_item_t;

	typedef struct packed {
		logic                      kind;
		logic signed [DATA_W-1:0]  y_value;
		logic signed [DATA_W-1:0]  state_value;
	} out_item_t;

	// A classified command as it waits between front and back.
	typedef struct packed {
		op_t                       op;
		logic [INDEX_W-1:0]        index;
		logic                      oob;
		logic signed [DATA_W-1:0]  value_a;
		logic signed [DATA_W-1:0]  value_b;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [3:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_DT_ARG,
		BK_DT_T,
		BK_DT_INT,
		BK_DT_FIN,
		BK_X_RD,
		BK_X_INC,
		BK_X_KEPT,
		BK_X_SUM,
		BK_X_CS,
		BK_X_ACC,
		BK_X_SKIP,
		BK_X_FIN,
		BK_RB_OUT
	} back_state_t;

	// Round a full Q32.32 product to Q16.16 (ties up) and saturate.
	function automatic logic signed [DATA_W-1:0] qround(input logic signed [63:0] p);
		logic [64:0] t;
		logic [48:0] w;
		t = {p[63], p} + 65'd32768;
		w = t[64:16];
		if (w[48:31] == '0 || w[48:31] == '1) begin
			return $signed(w[31:0]);
		end else if (w[48]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [32:0] v);
		if (v[32] == v[31]) begin
			return $signed(v[31:0]);
		end else if (v[32]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
			return $signed(v[31:0]);
		end else if (v[ACC_W-1]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

	// 65536 * 2^(-k/32) for k = 0..32.
	function automatic logic [16:0] pow2_tab(input logic [5:0] k);
		unique case (k)
			6'd0:  return 17'd65536;
			6'd1:  return 17'd64132;
			6'd2:  return 17'd62757;
			6'd3:  return 17'd61413;
			6'd4:  return 17'd60097;
			6'd5:  return 17'd58809;
			6'd6:  return 17'd57549;
			6'd7:  return 17'd56316;
			6'd8:  return 17'd55109;
			6'd9:  return 17'd53928;
			6'd10: return 17'd52773;
			6'd11: return 17'd51642;
			6'd12: return 17'd50535;
			6'd13: return 17'd49452;
			6'd14: return 17'd48393;
			6'd15: return 17'd47356;
			6'd16: return 17'd46341;
			6'd17: return 17'd45348;
			6'd18: return 17'd44376;
			6'd19: return 17'd43425;
			6'd20: return 17'd42495;
			6'd21: return 17'd41584;
			6'd22: return 17'd40693;
			6'd23: return 17'd39821;
			6'd24: return 17'd38968;
			6'd25: return 17'd38133;
			6'd26: return 17'd37316;
			6'd27: return 17'd36516;
			6'd28: return 17'd35734;
			6'd29: return 17'd34968;
			6'd30: return 17'd34219;
			6'd31: return 17'd33486;
			6'd32: return 17'd32768;
			default: return 17'd0;
		endcase
	endfunction

endpackage

### rtl/ssm_front.sv
// Front end: accepts input transfers, drops items that have no effect and
// classifies the rest into commands for the queue. Depends on ssm_pkg.
`timescale 1ns / 1ps

module ssm_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ssm_pkg::in_item_t     in_data,
	input  ssm_pkg::back_status_t status,
	input  logic                  full,
	output logic                  push,
	output ssm_pkg::cmd_t         push_cmd
);

	logic in_entry;
	logic keep;

	assign in_entry = 32'(in_data.index) < 32'(ssm_pkg::ENTRIES);

	always_comb begin
		unique case (in_data.op)
			ssm_pkg::OP_LOAD: keep = in_entry;
			ssm_pkg::OP_DT:   keep = 1'b1;
			ssm_pkg::OP_BC:   keep = 32'(in_data.index) < 32'(ssm_pkg::STATE_DIM);
			ssm_pkg::OP_X:    keep = 32'(in_data.index) < 32'(ssm_pkg::HEAD_DIM);
			ssm_pkg::OP_READ: keep = 1'b1;
			default:          keep = 1'b0;
		endcase
	end

	// Items are not taken while the state memory is being cleared.
	assign in_ready = !full && !status.clearing;
	assign push     = in_valid && in_ready && keep;

	always_comb begin
		push_cmd.op      = ssm_pkg::op_t'(in_data.op);
		push_cmd.index   = in_data.index;
		push_cmd.oob     = !in_entry;
		push_cmd.value_a = in_data.value_a;
		push_cmd.value_b = in_data.value_b;
	end

endmodule

### rtl/ssm_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on ssm_pkg for the command type and depth.
`timescale 1ns / 1ps

module ssm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssm_pkg::cmd_t push_cmd,
	input  logic          pop,
	output ssm_pkg::cmd_t head,
	output logic          head_valid,
	output logic          full
);

	ssm_pkg::cmd_t                 slots_q [ssm_pkg::QUEUE_DEPTH];
	logic [ssm_pkg::QPTR_W-1:0]    wr_q;
	logic [ssm_pkg::QPTR_W-1:0]    rd_q;
	logic [ssm_pkg::QCNT_W-1:0]    count_q;

	assign head       = slots_q[rd_q];
	assign head_valid = count_q != '0;
	assign full       = count_q == ssm_pkg::QCNT_W'(ssm_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_cmd;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from an empty queue");

endmodule

### rtl/ssm_back.sv
// Back end: configuration registers, state memory, B/C vectors, decay
// computation and the shared multiply sequencer. Depends on ssm_pkg.
`timescale 1ns / 1ps

module ssm_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ssm_pkg::DATA_W-1:0]          cfg_data,
	input  ssm_pkg::cmd_t                       head,
	input  logic                                head_valid,
	output logic                                pop,
	output ssm_pkg::back_status_t               status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ssm_pkg::out_item_t                  out_data
);

	localparam logic [ssm_pkg::N_W-1:0]    N_LAST   = ssm_pkg::N_W'(ssm_pkg::STATE_DIM - 1);
	localparam logic [ssm_pkg::ADDR_W-1:0] ADDR_LAST = ssm_pkg::ADDR_W'(ssm_pkg::ENTRIES - 1);
	localparam logic [ssm_pkg::ADDR_W-1:0] ADDR_STEP = ssm_pkg::ADDR_W'(ssm_pkg::HEAD_DIM);

	ssm_pkg::back_state_t state_q, state_d;

	logic signed [31:0] log_decay_q, skip_gain_q;
	logic               skip_en_q;
	logic signed [31:0] dt_q, decay_q;

	logic signed [31:0] b_q [ssm_pkg::STATE_DIM];
	logic signed [31:0] c_q [ssm_pkg::STATE_DIM];

	logic signed [31:0] mem [ssm_pkg::ENTRIES];
	logic signed [31:0] rd_q;

	ssm_pkg::cmd_t                    cmd_q;
	logic [ssm_pkg::N_W-1:0]          n_q;
	logic [ssm_pkg::ADDR_W-1:0]       addr_q;
	logic [ssm_pkg::ADDR_W-1:0]       clr_q;
	logic signed [ssm_pkg::ACC_W-1:0] acc_q;
	logic signed [31:0]               inc_q, s_q;
	logic signed [63:0]               prod_q;
	logic [33:0]                      t_q;
	logic [16:0]                      v_q;
	logic                             out_valid_q;
	ssm_pkg::out_item_t               out_q;

	// Combinational controls from the sequencer
	logic                             mem_we, mem_re;
	logic [ssm_pkg::ADDR_W-1:0]       mem_waddr, mem_raddr;
	logic signed [31:0]               mem_wdata;
	logic                             mul_en;
	logic signed [32:0]               mul_a, mul_b;
	logic                             out_load;
	ssm_pkg::out_item_t               out_next;

	// Datapath helpers
	logic                             out_free;
	logic signed [31:0]               prod_r;
	logic [32:0]                      neg_arg;
	logic signed [65:0]               mul_full;
	logic [63:0]                      t_sum;
	logic [5:0]                       seg;
	logic [10:0]                      rem;
	logic [16:0]                      hi, lo, diff;
	logic [27:0]                      interp_p;
	logic [27:0]                      interp_r;
	logic [4:0]                       ip;
	logic [32:0]                      shift_rnd, shift_sum, shift_res;
	logic signed [32:0]               s_sum;
	logic signed [31:0]               s_new;
	logic signed [ssm_pkg::ACC_W-1:0] acc_fin;

	assign out_free = !out_valid_q || out_ready;
	assign prod_r   = ssm_pkg::qround(prod_q);
	assign neg_arg  = 33'd0 - {prod_r[31], prod_r};
	assign mul_full = mul_a * mul_b;

	assign t_sum    = prod_q + 64'd536870912;
	assign seg      = {1'b0, t_q[15:11]};
	assign rem      = t_q[10:0];
	assign hi       = ssm_pkg::pow2_tab(seg);
	assign lo       = ssm_pkg::pow2_tab(seg + 6'd1);
	assign diff     = hi - lo;
	assign interp_p = 28'(diff) * 28'(rem);
	assign interp_r = (interp_p + 28'd1024) >> 11;
	assign ip       = t_q[20:16];
	assign shift_rnd = (33'd1 << ip) >> 1;
	assign shift_sum = {16'd0, v_q} + shift_rnd;
	assign shift_res = shift_sum >> ip;

	assign s_sum    = {prod_r[31], prod_r} + {inc_q[31], inc_q};
	assign s_new    = ssm_pkg::sat33(s_sum);
	assign acc_fin  = acc_q + (skip_en_q ? ssm_pkg::ACC_W'(prod_r) : '0);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssm_pkg::BK_CLEAR: begin
				if (clr_q == ADDR_LAST) state_d = ssm_pkg::BK_IDLE;
			end
			ssm_pkg::BK_IDLE: begin
				if (head_valid) begin
					unique case (head.op)
						ssm_pkg::OP_DT:   state_d = ssm_pkg::BK_DT_ARG;
						ssm_pkg::OP_X:    state_d = ssm_pkg::BK_X_RD;
						ssm_pkg::OP_READ: state_d = ssm_pkg::BK_RB_OUT;
						default:          state_d = ssm_pkg::BK_IDLE;
					endcase
				end
			end
			ssm_pkg::BK_DT_ARG: state_d = prod_r[31] ? ssm_pkg::BK_DT_T : ssm_pkg::BK_IDLE;
			ssm_pkg::BK_DT_T:   state_d = ssm_pkg::BK_DT_INT;
			ssm_pkg::BK_DT_INT: state_d = (t_q[33:21] != '0) ? ssm_pkg::BK_IDLE
			                                                 : ssm_pkg::BK_DT_FIN;
			ssm_pkg::BK_DT_FIN: state_d = ssm_pkg::BK_IDLE;
			ssm_pkg::BK_X_RD:   state_d = ssm_pkg::BK_X_INC;
			ssm_pkg::BK_X_INC:  state_d = ssm_pkg::BK_X_KEPT;
			ssm_pkg::BK_X_KEPT: state_d = ssm_pkg::BK_X_SUM;
			ssm_pkg::BK_X_SUM:  state_d = ssm_pkg::BK_X_CS;
			ssm_pkg::BK_X_CS:   state_d = ssm_pkg::BK_X_ACC;
			ssm_pkg::BK_X_ACC:  state_d = (n_q == N_LAST) ? ssm_pkg::BK_X_SKIP
			                                              : ssm_pkg::BK_X_RD;
			ssm_pkg::BK_X_SKIP: state_d = ssm_pkg::BK_X_FIN;
			ssm_pkg::BK_X_FIN: begin
				if (out_free) state_d = ssm_pkg::BK_IDLE;
			end
			ssm_pkg::BK_RB_OUT: begin
				if (out_free) state_d = ssm_pkg::BK_IDLE;
			end
			default: state_d = ssm_pkg::BK_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = addr_q;
		mem_raddr = addr_q;
		mem_wdata = s_new;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		pop       = 1'b0;
		out_load  = 1'b0;
		out_next  = '0;
		unique case (state_q)
			ssm_pkg::BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ssm_pkg::BK_IDLE: begin
				pop = head_valid;
				if (head_valid && head.op == ssm_pkg::OP_LOAD) begin
					mem_we    = 1'b1;
					mem_waddr = head.index[ssm_pkg::ADDR_W-1:0];
					mem_wdata = head.value_a;
				end
				if (head_valid && head.op == ssm_pkg::OP_READ) begin
					mem_re    = 1'b1;
					mem_raddr = head.index[ssm_pkg::ADDR_W-1:0];
				end
				if (head_valid && head.op == ssm_pkg::OP_DT) begin
					mul_en = 1'b1;
					mul_a  = 33'(log_decay_q);
					mul_b  = 33'(head.value_a);
				end
			end
			ssm_pkg::BK_DT_ARG: begin
				mul_en = 1'b1;
				mul_a  = $signed({1'b0, neg_arg[31:0]});
				mul_b  = $signed({2'b00, ssm_pkg::LOG2E_Q30});
			end
			ssm_pkg::BK_X_RD: begin
				mem_re = 1'b1;
				mul_en = 1'b1;
				mul_a  = 33'(b_q[n_q]);
				mul_b  = 33'(dt_q);
			end
			ssm_pkg::BK_X_INC: begin
				mul_en = 1'b1;
				mul_a  = 33'(prod_r);
				mul_b  = 33'(cmd_q.value_a);
			end
			ssm_pkg::BK_X_KEPT: begin
				mul_en = 1'b1;
				mul_a  = 33'(decay_q);
				mul_b  = 33'(rd_q);
			end
			ssm_pkg::BK_X_SUM: begin
				mem_we = 1'b1;
			end
			ssm_pkg::BK_X_CS: begin
				mul_en = 1'b1;
				mul_a  = 33'(c_q[n_q]);
				mul_b  = 33'(s_q);
			end
			ssm_pkg::BK_X_SKIP: begin
				mul_en = 1'b1;
				mul_a  = 33'(skip_gain_q);
				mul_b  = 33'(cmd_q.value_a);
			end
			ssm_pkg::BK_X_FIN: begin
				out_load             = out_free;
				out_next.kind        = ssm_pkg::KIND_Y;
				out_next.y_value     = ssm_pkg::sat_acc(acc_fin);
				out_next.state_value = '0;
			end
			ssm_pkg::BK_RB_OUT: begin
				out_load             = out_free;
				out_next.kind        = ssm_pkg::KIND_STATE;
				out_next.y_value     = '0;
				out_next.state_value = cmd_q.oob ? '0 : rd_q;
			end
			default: begin
			end
		endcase
	end

	// Control and architectural registers with a reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssm_pkg::BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			log_decay_q <= '0;
			skip_gain_q <= '0;
			skip_en_q   <= 1'b0;
			dt_q        <= '0;
			decay_q     <= ssm_pkg::Q_ONE;
		end else begin
			state_q <= state_d;
			if (state_q == ssm_pkg::BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					ssm_pkg::REG_LOG_DECAY:   log_decay_q <= $signed(cfg_data);
					ssm_pkg::REG_SKIP_GAIN:   skip_gain_q <= $signed(cfg_data);
					ssm_pkg::REG_SKIP_ENABLE: skip_en_q   <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (state_q == ssm_pkg::BK_IDLE && head_valid && head.op == ssm_pkg::OP_DT) begin
				dt_q <= head.value_a;
			end
			unique case (state_q)
				ssm_pkg::BK_DT_ARG: begin
					if (!prod_r[31]) decay_q <= ssm_pkg::Q_ONE;
				end
				ssm_pkg::BK_DT_INT: begin
					if (t_q[33:21] != '0) decay_q <= '0;
				end
				ssm_pkg::BK_DT_FIN: decay_q <= $signed(shift_res[31:0]);
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ssm_pkg::BK_IDLE && head_valid) begin
			cmd_q <= head;
			if (head.op == ssm_pkg::OP_BC) begin
				b_q[head.index[ssm_pkg::N_W-1:0]] <= head.value_a;
				c_q[head.index[ssm_pkg::N_W-1:0]] <= head.value_b;
			end
			if (head.op == ssm_pkg::OP_X) begin
				n_q    <= '0;
				addr_q <= head.index[ssm_pkg::ADDR_W-1:0];
				acc_q  <= '0;
			end
		end
		if (mul_en) begin
			prod_q <= $signed(mul_full[63:0]);
		end
		if (state_q == ssm_pkg::BK_DT_T) begin
			t_q <= t_sum[63:30];
		end
		if (state_q == ssm_pkg::BK_DT_INT) begin
			v_q <= hi - interp_r[16:0];
		end
		if (state_q == ssm_pkg::BK_X_KEPT) begin
			inc_q <= prod_r;
		end
		if (state_q == ssm_pkg::BK_X_SUM) begin
			s_q <= s_new;
		end
		if (state_q == ssm_pkg::BK_X_ACC) begin
			acc_q  <= acc_q + ssm_pkg::ACC_W'(prod_r);
			n_q    <= n_q + 1'b1;
			addr_q <= addr_q + ADDR_STEP;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	// State memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	assign status.clearing = state_q == ssm_pkg::BK_CLEAR;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssm_pkg::BK_CLEAR) |-> !pop) else $error("queue popped during clear");
	a_one_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re)) else $error("memory read and write in one cycle");
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssm_pkg::BK_X_RD) |-> (32'(addr_q) < 32'(ssm_pkg::ENTRIES)))
		else $error("column walk left the state memory");

endmodule

### rtl/ssm_selective_scan_head.sv
// Top level of one selective-scan head: front end, command queue, back end.
// Depends on ssm_pkg, ssm_front, ssm_queue and ssm_back.
//
//   port group  | dir | handshake        | content
//   in          | in  | in_valid/ready   | in_item_t: op, index, value_a, value_b
//   out         | out | out_valid/ready  | out_item_t: kind, y_value, state_value
//   cfg         | in  | cfg_we           | cfg_index, cfg_data (no wait)
//
// After reset the state memory is zeroed, one entry per cycle, with in_ready
// low; configuration writes are taken during that time.
// An x element walks every state row on the one shared 33x33 multiplier, then adds
// the skip term; set dt computes the decay from dt and the log decay.
// A two-entry queue lets the front accept while the back works or its
// result waits in the output register for out_ready.
`timescale 1ns / 1ps

module ssm_selective_scan_head (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ssm_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ssm_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssm_pkg::DATA_W-1:0]      cfg_data
);

	ssm_pkg::back_status_t status;
	ssm_pkg::cmd_t         push_cmd;
	ssm_pkg::cmd_t         head;
	logic                  push, pop, full, head_valid;

	ssm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.status   (status),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ssm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	ssm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.status     (status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
